// ===== rtl/core/assert_macros.svh =====
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge while reset is released.
`define KDSL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define KDSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KDSL_ASSERT(lbl, clk, rst_n, prop, msg)
`define KDSL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/core/kdsl_pkg.sv =====
`default_nettype none

package kdsl_pkg;

    localparam int NUM_KEYS  = 4;
    localparam int KEY_W     = NUM_KEYS;
    localparam int LONG_W    = 2;
    localparam int STAMP_W   = 32;
    localparam int CNT_W     = 8;
    localparam int MENU_W    = 8;
    localparam int DEB_W     = 8;
    localparam int LONG_T_W  = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam logic [DEB_W-1:0]    DEBOUNCE_RESET   = 8'd5;
    localparam logic [LONG_T_W-1:0] LONG_PRESS_RESET = 32'd1000;
    localparam logic [MENU_W-1:0]   CURSOR_RESET     = 8'd1;

    // Key roles by position in the key_levels word.
    localparam int KEY_RETURN = 0;
    localparam int KEY_SELECT = 1;
    localparam int KEY_UP     = 2;
    localparam int KEY_DOWN   = 3;

    typedef struct packed {
        logic short_press;
        logic long_press;
    } t_lane_evt;

    typedef struct packed {
        logic [KEY_W-1:0]  short_events;
        logic [LONG_W-1:0] long_events;
        logic              return_request;
        logic [MENU_W-1:0] select_count;
        logic [MENU_W-1:0] cursor;
        logic [MENU_W-1:0] add_count;
        logic [MENU_W-1:0] sub_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/kdsl_in_if.sv =====
`default_nettype none

interface kdsl_in_if;
    logic                        valid;
    logic                        ready;
    logic [kdsl_pkg::KEY_W-1:0]   key_levels;
    logic [kdsl_pkg::STAMP_W-1:0] time_now;

    modport source (output valid, output key_levels, output time_now, input ready);
    modport sink   (input valid, input key_levels, input time_now, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kdsl_out_if.sv =====
`default_nettype none

interface kdsl_out_if;
    logic                        valid;
    logic                        ready;
    logic [kdsl_pkg::KEY_W-1:0]  short_events;
    logic [kdsl_pkg::LONG_W-1:0] long_events;
    logic                        return_request;
    logic [kdsl_pkg::MENU_W-1:0] select_count;
    logic [kdsl_pkg::MENU_W-1:0] cursor;
    logic [kdsl_pkg::MENU_W-1:0] add_count;
    logic [kdsl_pkg::MENU_W-1:0] sub_count;

    modport source (
        output valid, output short_events, output long_events, output return_request,
        output select_count, output cursor, output add_count, output sub_count,
        input ready
    );
    modport sink (
        input valid, input short_events, input long_events, input return_request,
        input select_count, input cursor, input add_count, input sub_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/key_debounce_short_long_press.sv =====
// Four-key debouncer with short and long press detection and menu counters.
// Input channel i_in: one beat per scan tick, carrying the four active-low key
// levels and a wrapping timestamp. Output channel o_out: exactly one beat per
// input beat, carrying this scan's short and long press flags and the menu
// registers (return flag, select count, cursor, add and sub counts) after it.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_index
// (0 debounce ticks, 1 long press ticks); other indexes are ignored.
// The result is registered: a beat accepted at an edge is presented on o_out
// after that edge. Throughput is one beat per cycle unless o_out stalls; all
// four keys are evaluated by parallel lanes in the same cycle, and the slowest
// path is each lane's timestamp subtract and compare feeding the menu counters.
// A single output register separates the channels: while a result waits, a
// new beat is taken in the same cycle that the waiting one is taken.
// If the receiver stalls with a result pending, i_in.ready drops and key
// state is held. Reset (synchronous) returns all keys to released, clears the
// counters, sets the cursor to one, restores the configuration defaults and
// empties the output register; no beat is accepted while reset is held.
`default_nettype none

module key_debounce_short_long_press #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    kdsl_in_if.sink                                  i_in,
    kdsl_out_if.source                               o_out,
    input  wire logic                                i_cfg_we,
    input  wire logic [kdsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [kdsl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [kdsl_pkg::DEB_W-1:0]    r_debounce;
    logic [kdsl_pkg::LONG_T_W-1:0] r_long_ticks;
    logic                          r_out_valid;
    kdsl_pkg::t_result             r_out;
    kdsl_pkg::t_result             merged;
    kdsl_pkg::t_lane_evt [kdsl_pkg::NUM_KEYS-1:0] lane_evt;
    logic                          accept;

    assign i_in.ready = i_rst_n && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= kdsl_pkg::DEBOUNCE_RESET;
            r_long_ticks <= kdsl_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kdsl_pkg::CFG_DEBOUNCE:   r_debounce   <= i_cfg_wdata[kdsl_pkg::DEB_W-1:0];
                kdsl_pkg::CFG_LONG_PRESS: r_long_ticks <= i_cfg_wdata[kdsl_pkg::LONG_T_W-1:0];
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < kdsl_pkg::NUM_KEYS; k++) begin : g_lane
        kdsl_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (accept),
            .i_level      (i_in.key_levels[k]),
            .i_time_now   (i_in.time_now),
            .i_debounce   (r_debounce),
            .i_long_ticks (r_long_ticks),
            .o_evt        (lane_evt[k])
        );
    end

    kdsl_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_evt    (lane_evt),
        .o_result (merged)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= merged;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.short_events   = r_out.short_events;
    assign o_out.long_events    = r_out.long_events;
    assign o_out.return_request = r_out.return_request;
    assign o_out.select_count   = r_out.select_count;
    assign o_out.cursor         = r_out.cursor;
    assign o_out.add_count      = r_out.add_count;
    assign o_out.sub_count      = r_out.sub_count;

`include "assert_macros.svh"

    `KDSL_ASSERT(a_accept_gives_beat, i_clk, i_rst_n, accept |=> r_out_valid, "accepted scan produced no result beat")
    `KDSL_ASSERT(a_no_short_and_long, i_clk, i_rst_n, r_out_valid |-> !(r_out.short_events[kdsl_pkg::KEY_UP] && r_out.long_events[0]) && !(r_out.short_events[kdsl_pkg::KEY_DOWN] && r_out.long_events[1]), "key gave short and long press in one scan")
    `KDSL_ASSERT(a_cursor_still, i_clk, i_rst_n, accept && (lane_evt[kdsl_pkg::KEY_UP].short_press == lane_evt[kdsl_pkg::KEY_DOWN].short_press) |-> (merged.cursor == r_out.cursor || !r_out_valid || merged.cursor == u_merge.r_cursor), "cursor moved without a single cursor key press")
    `KDSL_ASSERT_ALWAYS(a_no_accept_in_reset, i_clk, !i_rst_n |-> !accept, "scan accepted while in reset")

endmodule

`default_nettype wire

// ===== rtl/core/kdsl_lane.sv =====
`default_nettype none

module kdsl_lane #(
    parameter int TIME_BITS = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_en,
    input  wire logic                             i_level,
    input  wire logic [kdsl_pkg::STAMP_W-1:0]     i_time_now,
    input  wire logic [kdsl_pkg::DEB_W-1:0]       i_debounce,
    input  wire logic [kdsl_pkg::LONG_T_W-1:0]    i_long_ticks,
    output kdsl_pkg::t_lane_evt                   o_evt
);

    localparam int CMP_W = (TIME_BITS > kdsl_pkg::LONG_T_W) ? TIME_BITS : kdsl_pkg::LONG_T_W;
    localparam logic [kdsl_pkg::CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'b00,
        PH_PRESSED  = 2'b01,
        PH_LONG     = 2'b11
    } t_phase;

    t_phase                       r_phase, n_phase;
    logic [kdsl_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [TIME_BITS-1:0]         r_press_time, n_press_time;
    logic [TIME_BITS-1:0]         now_t;
    logic [TIME_BITS-1:0]         held;
    logic [CMP_W-1:0]             held_ext;
    logic [CMP_W-1:0]             long_ext;

    assign now_t    = TIME_BITS'(i_time_now);
    assign held     = now_t - r_press_time;
    assign held_ext = CMP_W'(held);
    assign long_ext = CMP_W'(i_long_ticks);

    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_press_time = r_press_time;
        o_evt        = '0;
        if (!i_level) begin
            n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 8'd1;
            // A debounce setting of zero confirms on the first low scan.
            if (n_cnt >= i_debounce) begin
                unique case (r_phase)
                    PH_RELEASED: begin
                        n_phase      = PH_PRESSED;
                        n_press_time = now_t;
                    end
                    PH_PRESSED: begin
                        if (held_ext >= long_ext) begin
                            n_phase         = PH_LONG;
                            o_evt.long_press = 1'b1;
                        end
                    end
                    PH_LONG: begin
                        n_phase = PH_LONG;
                    end
                    default: begin
                        n_phase = PH_RELEASED;
                    end
                endcase
            end
        end else begin
            n_cnt = '0;
            // Release after a long press is silent.
            if (r_phase == PH_PRESSED) begin
                o_evt.short_press = 1'b1;
            end
            n_phase = PH_RELEASED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_press_time <= n_press_time;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/kdsl_merge.sv =====
`default_nettype none

module kdsl_merge (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_en,
    input  wire kdsl_pkg::t_lane_evt [kdsl_pkg::NUM_KEYS-1:0] i_evt,
    output kdsl_pkg::t_result                                o_result
);

    logic                        r_return, n_return;
    logic [kdsl_pkg::MENU_W-1:0] r_select, n_select;
    logic [kdsl_pkg::MENU_W-1:0] r_cursor, n_cursor;
    logic [kdsl_pkg::MENU_W-1:0] r_add, n_add;
    logic [kdsl_pkg::MENU_W-1:0] r_sub, n_sub;
    logic [kdsl_pkg::KEY_W-1:0]  shorts;
    logic [kdsl_pkg::LONG_W-1:0] longs;

    always_comb begin
        for (int k = 0; k < kdsl_pkg::NUM_KEYS; k++) begin
            shorts[k] = i_evt[k].short_press;
        end
        // Long presses of the return and select keys carry no event.
        longs = {i_evt[kdsl_pkg::KEY_DOWN].long_press, i_evt[kdsl_pkg::KEY_UP].long_press};
    end

    always_comb begin
        n_return = r_return | shorts[kdsl_pkg::KEY_RETURN];
        n_select = r_select + {7'd0, shorts[kdsl_pkg::KEY_SELECT]};
        n_add    = r_add + {7'd0, longs[0]};
        n_sub    = r_sub + {7'd0, longs[1]};
        // Up and down in the same beat cancel out.
        case ({shorts[kdsl_pkg::KEY_DOWN], shorts[kdsl_pkg::KEY_UP]})
            2'b01:   n_cursor = r_cursor + 8'd1;
            2'b10:   n_cursor = r_cursor - 8'd1;
            default: n_cursor = r_cursor;
        endcase
    end

    always_comb begin
        o_result.short_events   = shorts;
        o_result.long_events    = longs;
        o_result.return_request = n_return;
        o_result.select_count   = n_select;
        o_result.cursor         = n_cursor;
        o_result.add_count      = n_add;
        o_result.sub_count      = n_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_return <= 1'b0;
            r_select <= '0;
            r_cursor <= kdsl_pkg::CURSOR_RESET;
            r_add    <= '0;
            r_sub    <= '0;
        end else if (i_en) begin
            r_return <= n_return;
            r_select <= n_select;
            r_cursor <= n_cursor;
            r_add    <= n_add;
            r_sub    <= n_sub;
        end
    end

endmodule

`default_nettype wire
